/* rtl/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// shared types and widths for the reconnect backoff controller
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CountW    = 3;
  localparam int unsigned TimeoutW  = 20;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned NumDelays = 5;
  localparam int unsigned DelayIdxW = 3;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [CountW-1:0] CountMax = CountW'(4);

  typedef enum logic [ModeW-1:0] {
    MODE_TICK       = 3'd0,
    MODE_LOST       = 3'd1,
    MODE_START      = 3'd2,
    MODE_FAIL       = 3'd3,
    MODE_AUTH       = 3'd4,
    MODE_SET_STATUS = 3'd5,
    MODE_CANCEL     = 3'd6,
    MODE_HS_TIMEOUT = 3'd7
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OTHER        = 3'd0,
    ST_LOBBY        = 3'd1,
    ST_STARTING     = 3'd2,
    ST_INGAME       = 3'd3,
    ST_RECONNECTING = 3'd4
  } status_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_CLIENT_ROLE  = 3'd0,
    REG_RECV_TIMEOUT = 3'd1,
    REG_DELAY_FIRST  = 3'd2,
    REG_DELAY_SECOND = 3'd3,
    REG_DELAY_THIRD  = 3'd4,
    REG_DELAY_FOURTH = 3'd5,
    REG_DELAY_FIFTH  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic                                client_role;
    logic [TimeoutW-1:0]                 receive_timeout_ms;
    logic [NumDelays-1:0][DelayW-1:0]    delay;
  } cfg_t;

  typedef struct packed {
    status_e             status;
    logic                active;
    logic                bootstrap;
    logic [CountW-1:0]   fail_count;
    logic [TimeW-1:0]    deadline;
  } state_t;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [TimeW-1:0]    now_ms;
    logic [StatusW-1:0]  new_status;
    logic                peer_authenticated;
    logic [TimeW-1:0]    last_receive_ms;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0]  link_status;
    logic                reconnect_due;
    logic [CountW-1:0]   retry_count;
    logic                attempt_active;
    logic                waiting_bootstrap;
    logic [TimeW-1:0]    next_attempt_ms;
    logic                server_unreachable;
  } result_t;

endpackage

/* rtl/rbc_chan_if.sv */
// ----------------------------------------------------------------------------
// rbc channel interfaces
// valid/ready channels for event beats in and result beats out
// ----------------------------------------------------------------------------
interface rbc_evt_if;
  logic                         valid;
  logic                         ready;
  logic [rbc_pkg::ModeW-1:0]    mode;
  logic [rbc_pkg::TimeW-1:0]    now_ms;
  logic [rbc_pkg::StatusW-1:0]  new_status;
  logic                         peer_authenticated;
  logic [rbc_pkg::TimeW-1:0]    last_receive_ms;

  modport source (
    output valid, mode, now_ms, new_status, peer_authenticated, last_receive_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, new_status, peer_authenticated, last_receive_ms,
    output ready
  );
endinterface

interface rbc_res_if;
  logic                         valid;
  logic                         ready;
  logic [rbc_pkg::StatusW-1:0]  link_status;
  logic                         reconnect_due;
  logic [rbc_pkg::CountW-1:0]   retry_count;
  logic                         attempt_active;
  logic                         waiting_bootstrap;
  logic [rbc_pkg::TimeW-1:0]    next_attempt_ms;
  logic                         server_unreachable;

  modport source (
    output valid, link_status, reconnect_due, retry_count, attempt_active,
           waiting_bootstrap, next_attempt_ms, server_unreachable,
    input  ready
  );
  modport sink (
    input  valid, link_status, reconnect_due, retry_count, attempt_active,
           waiting_bootstrap, next_attempt_ms, server_unreachable,
    output ready
  );
endinterface

/* rtl/rbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rbc_cfg_regs
// apb register file: client role, receive timeout and retry delay table
// ----------------------------------------------------------------------------
module rbc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbc_pkg::AddrW-1:0]  paddr,
  input  logic [rbc_pkg::DataW-1:0]  pwdata,
  output logic [rbc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output rbc_pkg::cfg_t              cfg_o
);

  rbc_pkg::cfg_t     cfg_q;
  rbc_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = rbc_pkg::reg_idx_e'(paddr[rbc_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_role        <= 1'b1;
      cfg_q.receive_timeout_ms <= rbc_pkg::TimeoutW'(10000);
      cfg_q.delay[0]           <= rbc_pkg::DelayW'(250);
      cfg_q.delay[1]           <= rbc_pkg::DelayW'(500);
      cfg_q.delay[2]           <= rbc_pkg::DelayW'(1000);
      cfg_q.delay[3]           <= rbc_pkg::DelayW'(2000);
      cfg_q.delay[4]           <= rbc_pkg::DelayW'(5000);
    end else if (wr_en) begin
      unique case (reg_idx)
        rbc_pkg::REG_CLIENT_ROLE:  cfg_q.client_role <= pwdata[0];
        rbc_pkg::REG_RECV_TIMEOUT: begin
          cfg_q.receive_timeout_ms <= pwdata[rbc_pkg::TimeoutW-1:0];
        end
        rbc_pkg::REG_DELAY_FIRST:  cfg_q.delay[0] <= pwdata[rbc_pkg::DelayW-1:0];
        rbc_pkg::REG_DELAY_SECOND: cfg_q.delay[1] <= pwdata[rbc_pkg::DelayW-1:0];
        rbc_pkg::REG_DELAY_THIRD:  cfg_q.delay[2] <= pwdata[rbc_pkg::DelayW-1:0];
        rbc_pkg::REG_DELAY_FOURTH: cfg_q.delay[3] <= pwdata[rbc_pkg::DelayW-1:0];
        rbc_pkg::REG_DELAY_FIFTH:  cfg_q.delay[4] <= pwdata[rbc_pkg::DelayW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      rbc_pkg::REG_CLIENT_ROLE:  prdata = rbc_pkg::DataW'(cfg_q.client_role);
      rbc_pkg::REG_RECV_TIMEOUT: prdata = rbc_pkg::DataW'(cfg_q.receive_timeout_ms);
      rbc_pkg::REG_DELAY_FIRST:  prdata = rbc_pkg::DataW'(cfg_q.delay[0]);
      rbc_pkg::REG_DELAY_SECOND: prdata = rbc_pkg::DataW'(cfg_q.delay[1]);
      rbc_pkg::REG_DELAY_THIRD:  prdata = rbc_pkg::DataW'(cfg_q.delay[2]);
      rbc_pkg::REG_DELAY_FOURTH: prdata = rbc_pkg::DataW'(cfg_q.delay[3]);
      rbc_pkg::REG_DELAY_FIFTH:  prdata = rbc_pkg::DataW'(cfg_q.delay[4]);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* rtl/rbc_step.sv */
// ----------------------------------------------------------------------------
// rbc_step
// next-state and result logic for one event
// ----------------------------------------------------------------------------
module rbc_step (
  input  rbc_pkg::cfg_t    cfg_i,
  input  rbc_pkg::state_t  state_i,
  input  rbc_pkg::item_t   item_i,
  output rbc_pkg::state_t  state_o,
  output rbc_pkg::result_t res_o
);

  rbc_pkg::state_t               nx;
  rbc_pkg::mode_e                mode;
  logic                          client;
  logic                          recon;
  logic [rbc_pkg::CountW-1:0]    cnt_inc;
  logic                          fail_path;
  logic [rbc_pkg::DelayW-1:0]    delay_pick;
  logic [rbc_pkg::TimeW-1:0]     deadline_sum;
  logic [rbc_pkg::TimeW-1:0]     silence;
  logic [rbc_pkg::TimeW-1:0]     since_deadline;
  logic                          lost;
  logic                          check;
  logic                          use_add;
  logic                          unreach;
  logic                          due;

  // clamp to the last table entry
  function automatic logic [rbc_pkg::DelayW-1:0] delay_of(
    input rbc_pkg::cfg_t             cfg,
    input logic [rbc_pkg::CountW-1:0] cnt
  );
    logic [rbc_pkg::DelayIdxW-1:0] idx;
    idx = (cnt > rbc_pkg::CountMax) ? rbc_pkg::DelayIdxW'(rbc_pkg::NumDelays - 1)
                                    : rbc_pkg::DelayIdxW'(cnt);
    return cfg.delay[idx];
  endfunction

  assign mode    = rbc_pkg::mode_e'(item_i.mode);
  assign client  = cfg_i.client_role;
  assign recon   = (state_i.status == rbc_pkg::ST_RECONNECTING);
  assign cnt_inc = (state_i.fail_count < rbc_pkg::CountMax)
                   ? state_i.fail_count + rbc_pkg::CountW'(1) : state_i.fail_count;

  // attempt failed: explicit, or handshake timeout in an attempt or reconnect
  assign fail_path = (mode == rbc_pkg::MODE_FAIL) ||
                     ((mode == rbc_pkg::MODE_HS_TIMEOUT) && (state_i.active || recon));

  // one adder serves both schedule paths
  assign delay_pick   = fail_path ? delay_of(cfg_i, cnt_inc)
                                  : delay_of(cfg_i, state_i.fail_count);
  assign deadline_sum = item_i.now_ms + rbc_pkg::TimeW'(delay_pick);

  assign silence = item_i.now_ms - item_i.last_receive_ms;
  assign lost    = silence > rbc_pkg::TimeW'(cfg_i.receive_timeout_ms);
  assign check   = (state_i.status == rbc_pkg::ST_INGAME) ||
                   (client && ((state_i.status == rbc_pkg::ST_LOBBY) ||
                               (state_i.status == rbc_pkg::ST_STARTING)));

  assign since_deadline = item_i.now_ms - state_i.deadline;

  always_comb begin
    nx      = state_i;
    use_add = 1'b0;
    unreach = 1'b0;
    unique case (mode)
      rbc_pkg::MODE_TICK: begin
        if (check && client && item_i.peer_authenticated &&
            (item_i.last_receive_ms != '0) && lost && !recon) begin
          nx.status    = rbc_pkg::ST_RECONNECTING;
          nx.active    = 1'b0;
          nx.bootstrap = 1'b0;
          nx.deadline  = deadline_sum;
          use_add      = 1'b1;
        end
      end
      rbc_pkg::MODE_LOST: begin
        if (!recon) begin
          nx.status    = rbc_pkg::ST_RECONNECTING;
          nx.active    = 1'b0;
          nx.bootstrap = 1'b0;
          nx.deadline  = deadline_sum;
          use_add      = 1'b1;
        end
      end
      rbc_pkg::MODE_START: begin
        nx.active    = 1'b1;
        nx.bootstrap = 1'b0;
        nx.deadline  = '0;
      end
      rbc_pkg::MODE_AUTH: begin
        nx.active    = 1'b0;
        nx.bootstrap = state_i.active || state_i.bootstrap;
        if (!(state_i.active || state_i.bootstrap)) begin
          nx.fail_count = '0;
        end
        nx.deadline  = '0;
      end
      rbc_pkg::MODE_SET_STATUS: begin
        nx.status = (item_i.new_status > rbc_pkg::StatusW'(rbc_pkg::ST_RECONNECTING))
                    ? rbc_pkg::ST_OTHER : rbc_pkg::status_e'(item_i.new_status);
        if (client && (nx.status == rbc_pkg::ST_INGAME) && state_i.bootstrap) begin
          nx.active     = 1'b0;
          nx.bootstrap  = 1'b0;
          nx.fail_count = '0;
          nx.deadline   = '0;
        end
      end
      rbc_pkg::MODE_CANCEL: begin
        nx.active     = 1'b0;
        nx.bootstrap  = 1'b0;
        nx.fail_count = '0;
        nx.deadline   = '0;
      end
      rbc_pkg::MODE_FAIL, rbc_pkg::MODE_HS_TIMEOUT: begin
        if (fail_path) begin
          nx.status     = rbc_pkg::ST_RECONNECTING;
          nx.active     = 1'b0;
          nx.bootstrap  = 1'b0;
          nx.fail_count = cnt_inc;
          nx.deadline   = deadline_sum;
          use_add       = 1'b1;
        end else begin
          unreach = 1'b1;
        end
      end
      default: nx = state_i;
    endcase
  end

  // a freshly scheduled deadline sits delay ms ahead of now, so it is only
  // reached when that delay is zero; otherwise test the held deadline
  assign due = client && (nx.status == rbc_pkg::ST_RECONNECTING) && !nx.active &&
               (nx.deadline != '0) &&
               (use_add ? (delay_pick == '0) : !since_deadline[rbc_pkg::TimeW-1]);

  assign state_o = nx;

  always_comb begin
    res_o.link_status        = nx.status;
    res_o.reconnect_due      = due;
    res_o.retry_count        = nx.fail_count;
    res_o.attempt_active     = nx.active;
    res_o.waiting_bootstrap  = nx.bootstrap;
    res_o.next_attempt_ms    = nx.deadline;
    res_o.server_unreachable = unreach;
  end

endmodule

/* rtl/reconnect_backoff_controller_unit.sv */
// ----------------------------------------------------------------------------
// reconnect_backoff_controller_unit
// client link reconnect controller with capped, table-driven retry delay
// ----------------------------------------------------------------------------
// usage:
//   evt_i carries one event beat (mode, now_ms, new_status, peer flag and
//   last receive time); res_o returns exactly one result beat per event, in
//   order. both channels use valid/ready, a beat moves when both are high.
//   the apb port writes client role, receive timeout and the five retry
//   delays; write it only while no event is in flight.
// path: an accepted event beat goes into the input register, then into
//   the result register, which is written together with the link state.
// throughput: one event per cycle while res_o takes its results; the state
//   update is a single 32-bit add for the deadline plus compares, all
//   between the input and result registers.
// stall: when res_o is held off, the result register keeps its beat, the
//   input register takes one more event and then evt_i.ready drops until
//   the result is taken.
// reset: rst_ni clears both pipeline valids, the link state (status other,
//   no attempt, count 0, no deadline) and loads the register defaults.
// ----------------------------------------------------------------------------
module reconnect_backoff_controller_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rbc_evt_if.sink                    evt_i,
  rbc_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbc_pkg::AddrW-1:0]  paddr,
  input  logic [rbc_pkg::DataW-1:0]  pwdata,
  output logic [rbc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  rbc_pkg::cfg_t    cfg;
  rbc_pkg::state_t  state_q, state_nx;
  rbc_pkg::item_t   in_item_q;
  rbc_pkg::result_t out_res_q, step_res;
  logic             in_vld_q, in_vld_d;
  logic             out_vld_q, out_vld_d;
  logic             evt_accept;
  logic             out_free;
  logic             advance;

  // configuration registers
  rbc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline control: result register free, or being drained this cycle
  assign out_free    = !out_vld_q || res_o.ready;
  assign advance     = in_vld_q && out_free;
  assign evt_i.ready = !in_vld_q || advance;
  assign evt_accept  = evt_i.valid && evt_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (evt_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (evt_accept) begin
      in_item_q.mode               <= evt_i.mode;
      in_item_q.now_ms             <= evt_i.now_ms;
      in_item_q.new_status         <= evt_i.new_status;
      in_item_q.peer_authenticated <= evt_i.peer_authenticated;
      in_item_q.last_receive_ms    <= evt_i.last_receive_ms;
    end
  end

  // event evaluation against the current link state
  rbc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_nx),
    .res_o   (step_res)
  );

  // link state moves only when the event moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.status     <= rbc_pkg::ST_OTHER;
      state_q.active     <= 1'b0;
      state_q.bootstrap  <= 1'b0;
      state_q.fail_count <= '0;
      state_q.deadline   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_nx;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign res_o.valid              = out_vld_q;
  assign res_o.link_status        = out_res_q.link_status;
  assign res_o.reconnect_due      = out_res_q.reconnect_due;
  assign res_o.retry_count        = out_res_q.retry_count;
  assign res_o.attempt_active     = out_res_q.attempt_active;
  assign res_o.waiting_bootstrap  = out_res_q.waiting_bootstrap;
  assign res_o.next_attempt_ms    = out_res_q.next_attempt_ms;
  assign res_o.server_unreachable = out_res_q.server_unreachable;

  // link state must not move while a result beat is stuck at the output
  a_state_hold_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> $stable(state_q)
  ) else $error("link state changed while result stalled");

  // an attempt in progress never has a pending deadline
  a_active_no_deadline: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.attempt_active) |-> (out_res_q.next_attempt_ms == '0)
  ) else $error("attempt active with a deadline set");

  // a due report only comes while reconnecting with a nonzero deadline
  a_due_consistent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.reconnect_due) |->
      ((out_res_q.link_status == rbc_pkg::ST_RECONNECTING) &&
       (out_res_q.next_attempt_ms != '0))
  ) else $error("reconnect due outside reconnect");

  // the attempt count saturates
  a_count_cap: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.fail_count <= rbc_pkg::CountMax)
  ) else $error("attempt count above cap");

endmodule

/* dv/reconnect_backoff_controller_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reconnect_backoff_controller_unit_tb
// self-checking bench for the reconnect backoff controller: event beats go
// in with bursty gaps, result beats come out under a rotating stall pattern,
// and every result is checked field by field against a link state predictor
// kept in step with the apb register writes
// ----------------------------------------------------------------------------
module reconnect_backoff_controller_unit_tb;

  localparam int unsigned IdleLimit = 2000;  // cycles with no beat before giving up

  logic clk_i;
  logic rst_ni;

  // apb side
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rbc_pkg::AddrW-1:0]  paddr;
  logic [rbc_pkg::DataW-1:0]  pwdata;
  logic [rbc_pkg::DataW-1:0]  prdata;
  logic                       pready;

  rbc_evt_if evt();
  rbc_res_if res();

  reconnect_backoff_controller_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // predictor state: register copies and link tracking
  // --------------------------------------------------------------------------
  logic                          cfg_client;
  logic [rbc_pkg::TimeoutW-1:0]  cfg_timeout;
  logic [rbc_pkg::DelayW-1:0]    dly_tab [rbc_pkg::NumDelays];

  rbc_pkg::status_e              st_status;
  logic                          st_active;
  logic                          st_boot;
  logic [rbc_pkg::CountW-1:0]    st_count;
  logic [rbc_pkg::TimeW-1:0]     st_deadline;

  rbc_pkg::item_t    evt_pending_q [$];   // events not yet presented
  rbc_pkg::result_t  link_expect_q [$];   // predicted results, oldest first
  rbc_pkg::item_t    evt_cur;             // event currently on the bus
  int       burst_left;
  int       gap_left;
  int       mismatch_cnt;
  int       res_beats;
  int       queued_cnt;
  logic [rbc_pkg::TimeW-1:0] gen_now;     // running clock of the stimulus generator

  // retry deadline from the backoff table, count saturated at the table end
  function automatic logic [rbc_pkg::TimeW-1:0] backoff_deadline(
    logic [rbc_pkg::TimeW-1:0] now);
    return now + rbc_pkg::TimeW'(
      dly_tab[st_count > rbc_pkg::CountMax ? rbc_pkg::CountMax : st_count]);
  endfunction

  function automatic void clear_tracking();
    st_active   = 1'b0;
    st_boot     = 1'b0;
    st_count    = '0;
    st_deadline = '0;
  endfunction

  function automatic void enter_reconnect(logic [rbc_pkg::TimeW-1:0] now);
    if (st_status != rbc_pkg::ST_RECONNECTING) begin
      st_status   = rbc_pkg::ST_RECONNECTING;
      st_active   = 1'b0;
      st_boot     = 1'b0;
      st_deadline = backoff_deadline(now);
    end
  endfunction

  function automatic void fail_attempt(logic [rbc_pkg::TimeW-1:0] now);
    st_active = 1'b0;
    st_boot   = 1'b0;
    if (st_count < rbc_pkg::CountMax) begin
      st_count = st_count + 1'b1;
    end
    st_status   = rbc_pkg::ST_RECONNECTING;
    st_deadline = backoff_deadline(now);
  endfunction

  // advance the link state by one event and return the result it causes
  function automatic rbc_pkg::result_t step_link(rbc_pkg::item_t it);
    rbc_pkg::result_t          r;
    logic [rbc_pkg::TimeW-1:0] silence;
    logic [rbc_pkg::TimeW-1:0] slack;
    logic                      watch;
    logic                      was_busy;
    r = '0;
    silence = it.now_ms - it.last_receive_ms;
    case (rbc_pkg::mode_e'(it.mode))
      rbc_pkg::MODE_TICK: begin
        // receive watchdog only runs in game, or in lobby/starting on a client
        watch = (st_status == rbc_pkg::ST_INGAME) ||
                (cfg_client && (st_status == rbc_pkg::ST_LOBBY ||
                                st_status == rbc_pkg::ST_STARTING));
        if (watch && cfg_client && it.peer_authenticated && it.last_receive_ms != '0 &&
            silence > rbc_pkg::TimeW'(cfg_timeout)) begin
          enter_reconnect(it.now_ms);
        end
      end
      rbc_pkg::MODE_LOST: enter_reconnect(it.now_ms);
      rbc_pkg::MODE_START: begin
        st_active   = 1'b1;
        st_boot     = 1'b0;
        st_deadline = '0;
      end
      rbc_pkg::MODE_FAIL: fail_attempt(it.now_ms);
      rbc_pkg::MODE_AUTH: begin
        was_busy  = st_active | st_boot;
        st_active = 1'b0;
        st_boot   = was_busy;
        if (!was_busy) begin
          st_count = '0;
        end
        st_deadline = '0;
      end
      rbc_pkg::MODE_SET_STATUS: begin
        // codes past reconnecting fold to other
        st_status = (it.new_status > rbc_pkg::StatusW'(rbc_pkg::ST_RECONNECTING))
                    ? rbc_pkg::ST_OTHER : rbc_pkg::status_e'(it.new_status);
        if (cfg_client && st_status == rbc_pkg::ST_INGAME && st_boot) begin
          clear_tracking();
        end
      end
      rbc_pkg::MODE_CANCEL: clear_tracking();
      rbc_pkg::MODE_HS_TIMEOUT: begin
        if (st_active || st_status == rbc_pkg::ST_RECONNECTING) begin
          fail_attempt(it.now_ms);
        end else begin
          r.server_unreachable = 1'b1;
        end
      end
    endcase
    // signed wraparound compare against the deadline
    slack = it.now_ms - st_deadline;
    r.link_status       = st_status;
    r.reconnect_due     = cfg_client && st_status == rbc_pkg::ST_RECONNECTING &&
                          !st_active && st_deadline != '0 && !slack[rbc_pkg::TimeW-1];
    r.retry_count       = st_count;
    r.attempt_active    = st_active;
    r.waiting_bootstrap = st_boot;
    r.next_attempt_ms   = st_deadline;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [rbc_pkg::TimeW-1:0] got,
                               logic [rbc_pkg::TimeW-1:0] want);
    $display("[%0t] result beat %0d %s: got 0x%0h, expected 0x%0h",
             $realtime, res_beats, what, got, want);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // event driver: bursts of random length with random gaps, fed from the
  // pending queue; each accepted beat is run through the predictor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt.valid && evt.ready) begin
        link_expect_q.push_back(step_link(evt_cur));
      end
      if (!evt.valid || evt.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          evt.valid <= 1'b0;
        end else if (evt_pending_q.size() != 0) begin
          evt_cur = evt_pending_q.pop_front();
          evt.mode               <= evt_cur.mode;
          evt.now_ms             <= evt_cur.now_ms;
          evt.new_status         <= evt_cur.new_status;
          evt.peer_authenticated <= evt_cur.peer_authenticated;
          evt.last_receive_ms    <= evt_cur.last_receive_ms;
          evt.valid              <= 1'b1;
          if (burst_left <= 1) begin
            // new burst; a quarter of the time back to back, now and then long
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          evt.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: rotating ready pattern, reloaded when its countdown runs
  // out; one load in four never stalls
  // --------------------------------------------------------------------------
  logic [31:0] stall_pat;
  int          stall_left;

  always @(posedge clk_i) begin
    rbc_pkg::result_t want;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (link_expect_q.size() == 0) begin
          flag_mismatch("beat with nothing pending", res.next_attempt_ms, '0);
        end else begin
          want = link_expect_q.pop_front();
          if (res.link_status !== want.link_status)
            flag_mismatch("link_status", rbc_pkg::TimeW'(res.link_status),
                          rbc_pkg::TimeW'(want.link_status));
          if (res.reconnect_due !== want.reconnect_due)
            flag_mismatch("reconnect_due", rbc_pkg::TimeW'(res.reconnect_due),
                          rbc_pkg::TimeW'(want.reconnect_due));
          if (res.retry_count !== want.retry_count)
            flag_mismatch("retry_count", rbc_pkg::TimeW'(res.retry_count),
                          rbc_pkg::TimeW'(want.retry_count));
          if (res.attempt_active !== want.attempt_active)
            flag_mismatch("attempt_active", rbc_pkg::TimeW'(res.attempt_active),
                          rbc_pkg::TimeW'(want.attempt_active));
          if (res.waiting_bootstrap !== want.waiting_bootstrap)
            flag_mismatch("waiting_bootstrap", rbc_pkg::TimeW'(res.waiting_bootstrap),
                          rbc_pkg::TimeW'(want.waiting_bootstrap));
          if (res.next_attempt_ms !== want.next_attempt_ms)
            flag_mismatch("next_attempt_ms", res.next_attempt_ms, want.next_attempt_ms);
          if (res.server_unreachable !== want.server_unreachable)
            flag_mismatch("server_unreachable", rbc_pkg::TimeW'(res.server_unreachable),
                          rbc_pkg::TimeW'(want.server_unreachable));
        end
        res_beats++;
      end
      if (stall_left == 0) begin
        stall_pat  = ($urandom_range(0, 3) == 0) ? '1 : ($urandom() | 32'h1);
        stall_left = 48;
      end
      stall_left--;
      res.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends the run when no beat moves for too long
  // --------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((evt.valid && evt.ready) || (res.valid && res.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                   $realtime, idle_cycles, link_expect_q.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_evt(rbc_pkg::mode_e m, logic [rbc_pkg::TimeW-1:0] now,
                                   logic [rbc_pkg::StatusW-1:0] nst, logic peer,
                                   logic [rbc_pkg::TimeW-1:0] last);
    rbc_pkg::item_t it;
    it.mode               = m;
    it.now_ms             = now;
    it.new_status         = nst;
    it.peer_authenticated = peer;
    it.last_receive_ms    = last;
    evt_pending_q.push_back(it);
    queued_cnt++;
  endfunction

  // one well-formed link episode: settle in a status, lose the link, then a
  // few retries paced by the backoff table until one authenticates
  function automatic void queue_session();
    int                        tries;
    int                        fails;
    logic [rbc_pkg::TimeW-1:0] step_ms;
    logic [rbc_pkg::TimeW-1:0] silence;
    push_evt(rbc_pkg::MODE_SET_STATUS, gen_now,
             rbc_pkg::StatusW'($urandom_range(rbc_pkg::ST_LOBBY, rbc_pkg::ST_INGAME)),
             1'b1, '0);
    repeat ($urandom_range(0, 3)) begin
      gen_now += $urandom_range(1, 2000);
      push_evt(rbc_pkg::MODE_TICK, gen_now, rbc_pkg::StatusW'($urandom()), 1'b1,
               gen_now - $urandom_range(0, 50));
    end
    gen_now += $urandom_range(1, 500);
    if ($urandom_range(0, 2) != 0) begin
      // silence just past the timeout, sometimes exactly on it
      silence = rbc_pkg::TimeW'(cfg_timeout) + (($urandom_range(0, 4) == 0) ? 0
                                                : $urandom_range(1, 40));
      push_evt(rbc_pkg::MODE_TICK, gen_now, rbc_pkg::StatusW'($urandom()),
               $urandom_range(0, 7) != 0, gen_now - silence);
    end else begin
      push_evt(rbc_pkg::MODE_LOST, gen_now, rbc_pkg::StatusW'($urandom()),
               1'($urandom_range(0, 1)), $urandom());
    end
    fails = 0;
    tries = $urandom_range(1, 6);
    for (int i = 0; i < tries; i++) begin
      // land one short of the deadline now and then, otherwise on or past it
      step_ms = rbc_pkg::TimeW'(dly_tab[fails > 4 ? 4 : fails]);
      step_ms = ($urandom_range(0, 3) == 0) ? step_ms - 1 : step_ms + $urandom_range(0, 30);
      gen_now += step_ms;
      push_evt(rbc_pkg::MODE_TICK, gen_now, rbc_pkg::StatusW'($urandom()),
               1'($urandom_range(0, 1)), $urandom());
      gen_now += $urandom_range(0, 20);
      push_evt(rbc_pkg::MODE_START, gen_now, rbc_pkg::StatusW'($urandom()),
               1'($urandom_range(0, 1)), $urandom());
      gen_now += $urandom_range(1, 3000);
      if (i < tries - 1) begin
        push_evt(($urandom_range(0, 1) != 0) ? rbc_pkg::MODE_FAIL : rbc_pkg::MODE_HS_TIMEOUT,
                 gen_now, rbc_pkg::StatusW'($urandom()), 1'($urandom_range(0, 1)),
                 $urandom());
        fails++;
      end else begin
        push_evt(rbc_pkg::MODE_AUTH, gen_now, rbc_pkg::StatusW'($urandom()), 1'b1,
                 $urandom());
      end
    end
    gen_now += $urandom_range(1, 1000);
    case ($urandom_range(0, 3))
      0, 1: push_evt(rbc_pkg::MODE_SET_STATUS, gen_now,
                     rbc_pkg::StatusW'(rbc_pkg::ST_INGAME), 1'b1, gen_now);
      2:    push_evt(rbc_pkg::MODE_CANCEL, gen_now, rbc_pkg::StatusW'($urandom()),
                     1'($urandom_range(0, 1)), '0);
      default: push_evt(rbc_pkg::MODE_SET_STATUS, gen_now,
                        rbc_pkg::StatusW'($urandom_range(0, 7)), 1'b1, '0);
    endcase
  endfunction

  // mostly episodes, about one draw in six a fully random event
  function automatic void queue_random(int target);
    int base;
    base = queued_cnt;
    while (queued_cnt - base < target) begin
      if ($urandom_range(0, 5) == 0) begin
        push_evt(rbc_pkg::mode_e'($urandom_range(0, 7)), $urandom(),
                 rbc_pkg::StatusW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? '0 : $urandom());
      end else begin
        queue_session();
      end
    end
  endfunction

  // directed opening under the reset register values
  function automatic void queue_directed();
    push_evt(rbc_pkg::MODE_TICK,       32'd0,     3'd0, 1'b0, 32'd0);   // nothing to watch
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'd0,     3'd7, 1'b0, 32'd0);   // bad code folds
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'd0,     3'd5, 1'b1, 32'd0);
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'd10,    3'(rbc_pkg::ST_LOBBY), 1'b1, 32'd0);
    push_evt(rbc_pkg::MODE_TICK,       32'd20000, 3'd0, 1'b1, 32'd10000); // silence == timeout
    push_evt(rbc_pkg::MODE_TICK,       32'd20001, 3'd0, 1'b0, 32'd1);   // peer not authed
    push_evt(rbc_pkg::MODE_TICK,       32'd20001, 3'd0, 1'b1, 32'd0);   // nothing received yet
    push_evt(rbc_pkg::MODE_TICK,       32'd20001, 3'd0, 1'b1, 32'd1);   // link lost
    push_evt(rbc_pkg::MODE_LOST,       32'd20100, 3'd0, 1'b0, 32'd0);   // already reconnecting
    push_evt(rbc_pkg::MODE_TICK,       32'd20250, 3'd0, 1'b0, 32'd0);   // one short of due
    push_evt(rbc_pkg::MODE_TICK,       32'd20251, 3'd0, 1'b0, 32'd0);   // due
    push_evt(rbc_pkg::MODE_START,      32'd20260, 3'd0, 1'b0, 32'd0);
    push_evt(rbc_pkg::MODE_HS_TIMEOUT, 32'd20300, 3'd0, 1'b0, 32'd0);   // fails the attempt
    push_evt(rbc_pkg::MODE_FAIL, 32'hFFFF_FC18, 3'd0, 1'b0, 32'd0);     // deadline wraps to 0
    push_evt(rbc_pkg::MODE_FAIL, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF);
    push_evt(rbc_pkg::MODE_TICK, 32'd1999,      3'd0, 1'b0, 32'd0);     // due across the wrap
    push_evt(rbc_pkg::MODE_FAIL, 32'h7FFF_FFFF, 3'd0, 1'b0, 32'd0);     // count reaches the cap
    push_evt(rbc_pkg::MODE_FAIL, 32'h8000_0000, 3'd0, 1'b0, 32'd0);     // stays saturated
    push_evt(rbc_pkg::MODE_START, 32'h8000_0100, 3'd0, 1'b1, 32'd0);
    push_evt(rbc_pkg::MODE_AUTH,  32'h8000_0200, 3'd0, 1'b1, 32'd0);    // waits for bootstrap
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'h8000_0300, 3'(rbc_pkg::ST_INGAME), 1'b1,
             32'd0);                                                    // tracking clears
    push_evt(rbc_pkg::MODE_AUTH,  32'h8000_0400, 3'd0, 1'b1, 32'd0);    // fresh auth, count 0
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'h8000_0500, 3'(rbc_pkg::ST_RECONNECTING), 1'b0,
             32'd0);
    push_evt(rbc_pkg::MODE_HS_TIMEOUT, 32'h8000_0600, 3'd0, 1'b0, 32'd0); // fails, reconnecting
    push_evt(rbc_pkg::MODE_CANCEL, 32'h8000_0700, 3'd0, 1'b0, 32'd0);
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'h8000_0800, 3'(rbc_pkg::ST_STARTING), 1'b0,
             32'd0);
    push_evt(rbc_pkg::MODE_HS_TIMEOUT, 32'h8000_0900, 3'd0, 1'b0, 32'd0); // unreachable
    push_evt(rbc_pkg::MODE_SET_STATUS, 32'h8000_0A00, 3'(rbc_pkg::ST_INGAME), 1'b1, 32'd0);
    push_evt(rbc_pkg::MODE_TICK, 32'h0000_2711, 3'd0, 1'b1, 32'hFFFF_FFFF); // silence, wrap
  endfunction

  // apb write: setup cycle, access cycle, register taken when pready is high
  task automatic cfg_write(rbc_pkg::reg_idx_e idx, logic [rbc_pkg::DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      rbc_pkg::REG_CLIENT_ROLE:  cfg_client  = val[0];
      rbc_pkg::REG_RECV_TIMEOUT: cfg_timeout = val[rbc_pkg::TimeoutW-1:0];
      default: dly_tab[int'(idx) - int'(rbc_pkg::REG_DELAY_FIRST)] = val[rbc_pkg::DelayW-1:0];
    endcase
  endtask

  task automatic apply_cfg(logic role, logic [rbc_pkg::TimeoutW-1:0] tmo,
                           logic [rbc_pkg::NumDelays-1:0][rbc_pkg::DelayW-1:0] dl);
    cfg_write(rbc_pkg::REG_CLIENT_ROLE, rbc_pkg::DataW'(role));
    cfg_write(rbc_pkg::REG_RECV_TIMEOUT, rbc_pkg::DataW'(tmo));
    for (int k = 0; k < rbc_pkg::NumDelays; k++) begin
      cfg_write(rbc_pkg::reg_idx_e'(int'(rbc_pkg::REG_DELAY_FIRST) + k),
                rbc_pkg::DataW'(dl[k]));
    end
  endtask

  // test sequence waits until every event is sent and every predicted result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (evt_pending_q.size() != 0 || evt.valid || link_expect_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [rbc_pkg::NumDelays-1:0][rbc_pkg::DelayW-1:0] dl;
    // every input known from time zero
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    evt.valid              = 1'b0;
    evt.mode               = '0;
    evt.now_ms             = '0;
    evt.new_status         = '0;
    evt.peer_authenticated = 1'b0;
    evt.last_receive_ms    = '0;
    res.ready              = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
    stall_left   = 0;
    stall_pat    = '1;
    idle_cycles  = 0;
    mismatch_cnt = 0;
    res_beats    = 0;
    queued_cnt   = 0;
    // register defaults and cleared link state
    cfg_client  = 1'b1;
    cfg_timeout = rbc_pkg::TimeoutW'(10000);
    dly_tab[0]  = rbc_pkg::DelayW'(250);
    dly_tab[1]  = rbc_pkg::DelayW'(500);
    dly_tab[2]  = rbc_pkg::DelayW'(1000);
    dly_tab[3]  = rbc_pkg::DelayW'(2000);
    dly_tab[4]  = rbc_pkg::DelayW'(5000);
    st_status   = rbc_pkg::ST_OTHER;
    clear_tracking();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    wait_drained();

    // timeout and all delays of 1, time starting just short of the wrap
    apply_cfg(1'b1, rbc_pkg::TimeoutW'(1), {rbc_pkg::NumDelays{rbc_pkg::DelayW'(1)}});
    gen_now = 32'hFFFF_F000;
    queue_random(95);
    wait_drained();

    // timeout of 1000000 and the longest delays
    apply_cfg(1'b1, rbc_pkg::TimeoutW'(1000000),
              {rbc_pkg::NumDelays{rbc_pkg::DelayW'(65535)}});
    gen_now = $urandom();
    queue_random(95);
    wait_drained();

    // host role: the watchdog stays quiet, transport loss still reconnects
    for (int k = 0; k < rbc_pkg::NumDelays; k++) begin
      dl[k] = rbc_pkg::DelayW'($urandom_range(1, 65535));
    end
    apply_cfg(1'b0, rbc_pkg::TimeoutW'($urandom_range(1, 1000000)), dl);
    gen_now = $urandom();
    queue_random(95);
    wait_drained();

    // back to client with a random short table
    for (int k = 0; k < rbc_pkg::NumDelays; k++) begin
      dl[k] = rbc_pkg::DelayW'($urandom_range(1, 4000));
    end
    apply_cfg(1'b1, rbc_pkg::TimeoutW'($urandom_range(1, 30000)), dl);
    gen_now = $urandom();
    queue_random(95);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (link_expect_q.size() != 0) begin
      flag_mismatch("results never returned", link_expect_q.size(), '0);
    end
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
